@@ design/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk and quiet during reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// expression must never be true out of reset
`define ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

@@ design/ctbi_pkg.sv @@
// ----------------------------------------------------------------------------
// ctbi_pkg
// types, constants and helpers shared by the text-to-integer converter
// ----------------------------------------------------------------------------
`default_nettype none

package ctbi_pkg;

    // alphabet sizing
    localparam int MAX_ALPHABET = 16;
    localparam int LEN_W        = 5;
    localparam int DIGIT_W      = $clog2(MAX_ALPHABET);
    localparam int CHAR_W       = 8;
    localparam int ACC_W        = 32;

    // configuration port
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 5;

    localparam logic [1:0] REG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] REG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] REG_ALPHA_LEN  = 2'd2;

    // queue between front and back
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    // character codes
    localparam logic [CHAR_W-1:0] CHR_PLUS  = 8'h2B;
    localparam logic [CHAR_W-1:0] CHR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHR_WS_LO = 8'h09;
    localparam logic [CHAR_W-1:0] CHR_WS_HI = 8'h0F;
    localparam logic [CHAR_W-1:0] CHR_NUL   = 8'h00;

    typedef enum logic [1:0] {
        PH_SPACE,
        PH_SIGN,
        PH_DIGIT,
        PH_DONE
    } parse_phase_t;

    typedef enum logic [2:0] {
        CLS_SPACE,
        CLS_PLUS,
        CLS_MINUS,
        CLS_DIGIT,
        CLS_OTHER
    } char_class_t;

    // configuration as seen by the front
    typedef struct packed {
        logic [CFG_DATA_W-1:0] alpha_low;
        logic [CFG_DATA_W-1:0] alpha_high;
        logic [LEN_W-1:0]      alpha_len;
        logic                  alpha_ok;
    } cfg_t;

    // one classified item in the queue
    typedef struct packed {
        char_class_t          cls;
        logic [DIGIT_W-1:0]   digit;
        logic [LEN_W-1:0]     radix;
        logic                 alpha_ok;
        logic                 first;
        logic                 last;
    } item_t;

    // tab, line feed and friends, or a plain space
    function automatic logic is_space_char(input logic [CHAR_W-1:0] c);
        is_space_char = (c == CHR_SPACE) || ((c >= CHR_WS_LO) && (c <= CHR_WS_HI));
    endfunction

    // digit character k out of the two packed alphabet words
    function automatic logic [CHAR_W-1:0] alpha_char(
        input logic [CFG_DATA_W-1:0] low,
        input logic [CFG_DATA_W-1:0] high,
        input int                    k
    );
        logic [2*CFG_DATA_W-1:0] both;
        both       = {high, low};
        alpha_char = both[k*CHAR_W +: CHAR_W];
    endfunction

endpackage

`default_nettype wire

@@ design/ctbi_cfg.sv @@
// ----------------------------------------------------------------------------
// ctbi_cfg
// register file on the APB-style port and the alphabet validity check
// ----------------------------------------------------------------------------
`default_nettype none

module ctbi_cfg
    import ctbi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output cfg_t                       cfg
);

    logic [CFG_DATA_W-1:0] alpha_low_reg;
    logic [CFG_DATA_W-1:0] alpha_high_reg;
    logic [LEN_W-1:0]      alpha_len_reg;
    logic [1:0]            reg_index;
    logic                  wr_en;
    logic [MAX_ALPHABET-1:0] used;
    logic                  bad_char;
    logic                  dup_char;
    logic                  len_ok;

    assign pready    = 1'b1;
    assign reg_index = paddr[CFG_ADDR_W-1:3];
    assign wr_en     = psel && penable && pwrite && pready;

    // register writes, unknown addresses dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            alpha_len_reg  <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_index)
                REG_ALPHA_LOW:  alpha_low_reg  <= pwdata;
                REG_ALPHA_HIGH: alpha_high_reg <= pwdata;
                REG_ALPHA_LEN:  alpha_len_reg  <= pwdata[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // read back
    always_comb
    begin
        unique case (reg_index)
            REG_ALPHA_LOW:  prdata = alpha_low_reg;
            REG_ALPHA_HIGH: prdata = alpha_high_reg;
            REG_ALPHA_LEN:  prdata = {{(CFG_DATA_W-LEN_W){1'b0}}, alpha_len_reg};
            default:        prdata = '0;
        endcase
    end

    // alphabet check: forbidden characters and duplicates among digits in use
    always_comb
    begin
        bad_char = 1'b0;
        dup_char = 1'b0;
        for (int i = 0; i < MAX_ALPHABET; i++)
        begin
            used[i] = (LEN_W'(i) < alpha_len_reg);
        end
        for (int i = 0; i < MAX_ALPHABET; i++)
        begin
            if (used[i])
            begin
                if ((alpha_char(alpha_low_reg, alpha_high_reg, i) == CHR_NUL) ||
                    (alpha_char(alpha_low_reg, alpha_high_reg, i) == CHR_PLUS) ||
                    (alpha_char(alpha_low_reg, alpha_high_reg, i) == CHR_MINUS) ||
                    is_space_char(alpha_char(alpha_low_reg, alpha_high_reg, i)))
                begin
                    bad_char = 1'b1;
                end
            end
            for (int j = i + 1; j < MAX_ALPHABET; j++)
            begin
                if (used[j] && (alpha_char(alpha_low_reg, alpha_high_reg, i) ==
                                alpha_char(alpha_low_reg, alpha_high_reg, j)))
                begin
                    dup_char = 1'b1;
                end
            end
        end
    end

    assign len_ok = (alpha_len_reg >= LEN_W'(2)) && (alpha_len_reg <= LEN_W'(MAX_ALPHABET));

    assign cfg.alpha_low  = alpha_low_reg;
    assign cfg.alpha_high = alpha_high_reg;
    assign cfg.alpha_len  = alpha_len_reg;
    assign cfg.alpha_ok   = len_ok && !bad_char && !dup_char;

endmodule

`default_nettype wire

@@ design/ctbi_front.sv @@
// ----------------------------------------------------------------------------
// ctbi_front
// accepts characters and classifies them against the digit alphabet
// ----------------------------------------------------------------------------
`default_nettype none

module ctbi_front
    import ctbi_pkg::*;
(
    input  wire logic              text_valid,
    output logic                   text_stall,
    input  wire logic [CHAR_W-1:0] text_char,
    input  wire logic              string_start,
    input  wire logic              string_end,
    input  wire cfg_t              cfg,
    input  wire logic              q_full,
    output logic                   push,
    output item_t                  wr_item
);

    logic [MAX_ALPHABET-1:0] hit;
    logic [DIGIT_W-1:0]      hit_index;
    logic                    is_digit;
    char_class_t             cls;

    // stall while the queue has no room
    assign text_stall = q_full;
    assign push       = text_valid && !q_full;

    // parallel compare against every digit in use, lowest index wins
    always_comb
    begin
        hit_index = '0;
        for (int i = 0; i < MAX_ALPHABET; i++)
        begin
            hit[i] = (LEN_W'(i) < cfg.alpha_len) &&
                     (alpha_char(cfg.alpha_low, cfg.alpha_high, i) == text_char);
        end
        for (int i = MAX_ALPHABET - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                hit_index = DIGIT_W'(i);
            end
        end
    end

    assign is_digit = cfg.alpha_ok && (hit != '0);

    // character class, whitespace and signs ahead of digits
    always_comb
    begin
        if (is_space_char(text_char))
        begin
            cls = CLS_SPACE;
        end
        else if (text_char == CHR_PLUS)
        begin
            cls = CLS_PLUS;
        end
        else if (text_char == CHR_MINUS)
        begin
            cls = CLS_MINUS;
        end
        else if (is_digit)
        begin
            cls = CLS_DIGIT;
        end
        else
        begin
            cls = CLS_OTHER;
        end
    end

    assign wr_item.cls      = cls;
    assign wr_item.digit    = hit_index;
    assign wr_item.radix    = cfg.alpha_len;
    assign wr_item.alpha_ok = cfg.alpha_ok;
    assign wr_item.first    = string_start;
    assign wr_item.last     = string_end;

endmodule

`default_nettype wire

@@ design/ctbi_queue.sv @@
// ----------------------------------------------------------------------------
// ctbi_queue
// short first-in first-out queue of classified items
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ctbi_queue
    import ctbi_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t wr_item,
    output logic       full,
    input  wire logic  pop,
    output logic       rd_valid,
    output item_t      rd_item
);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0]  count_reg;
    logic [QPTR_W-1:0]  wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_next;
    logic [QCNT_W-1:0]  count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // item storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `ASSERT_CLK(a_queue_fill, (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1), "queue count did not rise on push")
    `ASSERT_NEVER(a_queue_pop_empty, pop && !rd_valid, "pop from empty queue")

endmodule

`default_nettype wire

@@ design/ctbi_back.sv @@
// ----------------------------------------------------------------------------
// ctbi_back
// parse sequencer, signed multiply-add accumulator and result register
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ctbi_back
    import ctbi_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            q_valid,
    input  wire item_t           q_item,
    output logic                 pop,
    output logic                 result_valid,
    input  wire logic            result_stall,
    output logic signed [ACC_W-1:0] parsed_value,
    output logic                 alphabet_invalid
);

    parse_phase_t             phase_reg;
    parse_phase_t             phase_next;
    logic                     parity_reg;
    logic                     parity_next;
    logic [ACC_W-1:0]         acc_reg;
    logic [ACC_W-1:0]         acc_next;
    logic                     result_valid_reg;
    logic                     result_valid_next;
    logic signed [ACC_W-1:0]  value_reg;
    logic signed [ACC_W-1:0]  value_next;
    logic                     invalid_reg;
    logic                     invalid_next;

    parse_phase_t             ph_entry;
    parse_phase_t             ph_sign;
    parse_phase_t             ph_digit;
    parse_phase_t             ph_end;
    logic                     sign_flip;
    logic                     digit_take;
    logic                     slot_free;

    logic                     par_cur;
    logic [ACC_W-1:0]         acc_cur;
    logic [ACC_W-1:0]         product;
    logic [ACC_W-1:0]         digit_term;
    logic [ACC_W-1:0]         acc_new;

    // an item ending a string needs the result slot
    assign slot_free = !result_valid_reg || !result_stall;
    assign pop       = q_valid && (!q_item.last || slot_free);

    // next phase: whitespace, signs and digits may all fall through on one item
    always_comb
    begin
        ph_entry = q_item.first ? PH_SPACE : phase_reg;

        ph_sign = ph_entry;
        if ((ph_entry == PH_SPACE) && (q_item.cls != CLS_SPACE))
        begin
            ph_sign = PH_SIGN;
        end

        ph_digit  = ph_sign;
        sign_flip = 1'b0;
        if (ph_sign == PH_SIGN)
        begin
            unique case (q_item.cls)
                CLS_MINUS: sign_flip = 1'b1;
                CLS_PLUS:  ;
                default:   ph_digit  = PH_DIGIT;
            endcase
        end

        ph_end     = ph_digit;
        digit_take = 1'b0;
        if (ph_digit == PH_DIGIT)
        begin
            if (q_item.cls == CLS_DIGIT)
            begin
                digit_take = 1'b1;
            end
            else
            begin
                ph_end = PH_DONE;
            end
        end

        if (!pop)
        begin
            phase_next = phase_reg;
        end
        else if (q_item.last)
        begin
            phase_next = PH_SPACE;
        end
        else
        begin
            phase_next = ph_end;
        end
    end

    // accumulator keeps the signed value: digits added or taken off by parity
    always_comb
    begin
        par_cur    = q_item.first ? 1'b0 : parity_reg;
        acc_cur    = q_item.first ? '0 : acc_reg;
        product    = acc_cur * {{(ACC_W-LEN_W){1'b0}}, q_item.radix};
        digit_term = {{(ACC_W-DIGIT_W){1'b0}}, q_item.digit};
        if (par_cur)
        begin
            digit_term = '0 - digit_term;
        end
        acc_new = digit_take ? (product + digit_term) : acc_cur;

        parity_next       = parity_reg;
        acc_next          = acc_reg;
        value_next        = value_reg;
        invalid_next      = invalid_reg;
        result_valid_next = result_valid_reg && result_stall;

        if (pop)
        begin
            if (q_item.last)
            begin
                parity_next       = 1'b0;
                acc_next          = '0;
                value_next        = q_item.alpha_ok ? signed'(acc_new) : '0;
                invalid_next      = !q_item.alpha_ok;
                result_valid_next = 1'b1;
            end
            else
            begin
                parity_next = par_cur ^ sign_flip;
                acc_next    = acc_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SPACE;
            parity_reg       <= 1'b0;
            acc_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            parity_reg       <= parity_next;
            acc_reg          <= acc_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        value_reg   <= value_next;
        invalid_reg <= invalid_next;
    end

    assign result_valid     = result_valid_reg;
    assign parsed_value     = value_reg;
    assign alphabet_invalid = invalid_reg;

    `ASSERT_CLK(a_back_clear, (pop && q_item.last) |=> (phase_reg == PH_SPACE && acc_reg == '0 && !parity_reg && result_valid_reg), "parse state not cleared after a result")
    `ASSERT_CLK(a_back_zero, (result_valid_reg && invalid_reg) |-> (value_reg == '0), "invalid alphabet with non-zero value")
    `ASSERT_NEVER(a_back_overrun, q_valid && q_item.last && result_valid_reg && result_stall && pop, "result slot overwritten")

endmodule

`default_nettype wire

@@ design/custom_base_text_to_integer_top.sv @@
// ----------------------------------------------------------------------------
// custom_base_text_to_integer_top
// text to integer converter with a configurable digit alphabet
// ----------------------------------------------------------------------------
// Takes one string character per cycle while text_stall is low. The front
// classifies each item in the cycle it is accepted and writes it into a
// two-entry queue; the back retires one item per cycle through a single
// 32 x 5 bit multiply-add, which sets the rate, save a string's last item
// while a pending result is stalled. The result holds on result_valid while
// result_stall is high; text_stall rises only when the queue is full.
// Registers sit at byte addresses 0x00 (digits 0 to 7), 0x08 (digits 8 to
// 15) and 0x10 (length), 64 bits wide; the user must change them only while
// no string is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module custom_base_text_to_integer_top
    import ctbi_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    input  wire logic                  text_valid,
    output logic                       text_stall,
    input  wire logic [CHAR_W-1:0]     text_char,
    input  wire logic                  string_start,
    input  wire logic                  string_end,
    output logic                       result_valid,
    input  wire logic                  result_stall,
    output logic signed [ACC_W-1:0]    parsed_value,
    output logic                       alphabet_invalid
);

    cfg_t  cfg;
    item_t wr_item;
    item_t rd_item;
    logic  push;
    logic  q_full;
    logic  pop;
    logic  q_valid;

    // configuration registers
    ctbi_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // character intake and classification
    ctbi_front u_front (
        .text_valid   (text_valid),
        .text_stall   (text_stall),
        .text_char    (text_char),
        .string_start (string_start),
        .string_end   (string_end),
        .cfg          (cfg),
        .q_full       (q_full),
        .push         (push),
        .wr_item      (wr_item)
    );

    // decoupling queue
    ctbi_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .wr_item  (wr_item),
        .full     (q_full),
        .pop      (pop),
        .rd_valid (q_valid),
        .rd_item  (rd_item)
    );

    // parsing and accumulation
    ctbi_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .q_valid          (q_valid),
        .q_item           (rd_item),
        .pop              (pop),
        .result_valid     (result_valid),
        .result_stall     (result_stall),
        .parsed_value     (parsed_value),
        .alphabet_invalid (alphabet_invalid)
    );

endmodule

`default_nettype wire
